// ===== sv/ifss_pkg.sv =====
package ifss_pkg;

  // Framing bytes.
  localparam logic [7:0] FrameFlag  = 8'h7E;
  localparam logic [7:0] EscapeByte = 8'h7D;
  localparam logic [7:0] FlagSub    = 8'h5E;
  localparam logic [7:0] EscSub     = 8'h5D;

  // Control field codes.
  localparam logic [7:0] CtlI0   = 8'h00;
  localparam logic [7:0] CtlI1   = 8'h40;
  localparam logic [7:0] CtlRr0  = 8'h05;
  localparam logic [7:0] CtlRr1  = 8'h85;
  localparam logic [7:0] CtlRej0 = 8'h01;
  localparam logic [7:0] CtlRej1 = 8'h81;

  localparam logic [7:0] AddrReset = 8'h03;

  // Largest number of line bytes one payload byte can cause.
  localparam int unsigned MaxResults = 9;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned HeaderLen  = 4;

  // Result kinds (tuser on the result side).
  localparam logic KindTx     = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Commands (tuser on the item side).
  localparam logic CmdPayload = 1'b0;
  localparam logic CmdLine    = 1'b1;

  typedef enum logic [1:0] {
    EvNone       = 2'd0,
    EvAck        = 2'd1,
    EvRetransmit = 2'd2
  } event_t;

  typedef enum logic [4:0] {
    PsStart = 5'b00001,
    PsFlag  = 5'b00010,
    PsAddr  = 5'b00100,
    PsCtrl  = 5'b01000,
    PsCheck = 5'b10000
  } parse_state_t;

endpackage

// ===== sv/info_frame_sender_stuffing_ack.sv =====
// Sending side of a stop-and-wait link with a byte-stuffing framer.
// Words enter on the s_ group: tuser selects a payload byte to send (0) or a
// byte received from the line (1), tdata carries the byte, and tlast marks the
// final payload byte of a frame. Words leave on the m_ group: tuser is the
// kind (0 line byte, 1 response status), tdata holds the line byte, the event
// code and the current sequence bit, and tlast marks the last word caused by
// one input word. The user must write the address register through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce it.
// An accepted word sits in an input register; in the next cycle in which the
// result buffer is empty or handing out its final word, one pass of logic
// frames or parses it and loads all of its results into a nine-byte shift
// buffer, which has a single output port and hands out one word per cycle
// while m_tready is high: a line byte yields one status word, a payload byte
// one to nine line bytes. The input register takes a new word while results
// still wait downstream. A stall on m_tready holds the buffer, then the input
// register, then s_tready. Reset empties both stages, closes any open frame,
// clears the sequence bit and check byte, restarts the parser and sets the
// address to 3.
module info_frame_sender_stuffing_ack (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] command
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] tx_byte, [9:8] event_res, [10] sequence_bit
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast    // run_end
);

  localparam int unsigned Nr = ifss_pkg::MaxResults;
  localparam int unsigned Cw = ifss_pkg::CntW;

  logic [7:0] tx_address;

  // Input register.
  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_data;
  logic       in_last;

  // Link state.
  logic                   seq_bit;
  logic                   seq_bit_next;
  logic                   in_frame;
  logic [7:0]             check_accum;
  logic [7:0]             check_accum_next;
  ifss_pkg::parse_state_t parse_state;
  ifss_pkg::parse_state_t parse_state_next;
  logic [7:0]             captured_control;
  logic [7:0]             captured_control_next;
  ifss_pkg::event_t       ev;

  // Result buffer.
  logic [7:0]       res_bytes [Nr];
  logic [Cw-1:0]    res_cnt;
  logic             res_kind;
  ifss_pkg::event_t res_event;
  logic             res_seq;

  logic buf_free;
  logic load;
  logic pop;

  // Framing of one payload byte.
  logic [7:0]    frame_bytes [Nr];
  logic [Cw-1:0] frame_cnt;
  logic [7:0]    hdr_ctl;
  logic [7:0]    check_new;
  logic [Cw-1:0] hdr_len;
  logic [Cw-1:0] data_len;
  logic [Cw-1:0] chk_len;
  logic [Cw-1:0] chk_pos;
  logic [Cw-1:0] flag_pos;
  logic [7:0]    data_b0;
  logic [7:0]    data_b1;
  logic [7:0]    chk_b0;
  logic [7:0]    chk_b1;
  logic          data_esc;
  logic          chk_esc;

  assign pop      = m_tvalid && m_tready;
  assign buf_free = (res_cnt == '0) || (pop && res_cnt == Cw'(1));
  assign load     = in_valid && buf_free;
  assign s_tready = !in_valid || load;

  always_comb begin
    hdr_ctl   = seq_bit ? ifss_pkg::CtlI1 : ifss_pkg::CtlI0;
    check_new = (in_frame ? check_accum : 8'h00) ^ in_data;

    data_esc = (in_data == ifss_pkg::FrameFlag) || (in_data == ifss_pkg::EscapeByte);
    data_b0  = data_esc ? ifss_pkg::EscapeByte : in_data;
    data_b1  = (in_data == ifss_pkg::FrameFlag) ? ifss_pkg::FlagSub : ifss_pkg::EscSub;
    chk_esc  = (check_new == ifss_pkg::FrameFlag) || (check_new == ifss_pkg::EscapeByte);
    chk_b0   = chk_esc ? ifss_pkg::EscapeByte : check_new;
    chk_b1   = (check_new == ifss_pkg::FrameFlag) ? ifss_pkg::FlagSub : ifss_pkg::EscSub;

    hdr_len  = in_frame ? '0 : Cw'(ifss_pkg::HeaderLen);
    data_len = data_esc ? Cw'(2) : Cw'(1);
    chk_len  = chk_esc ? Cw'(2) : Cw'(1);
    chk_pos  = hdr_len + data_len;
    flag_pos = chk_pos + chk_len;
    frame_cnt = in_last ? flag_pos + Cw'(1) : chk_pos;

    // Each slot picks the byte whose offset lands on it.
    for (int k = 0; k < Nr; k++) begin
      frame_bytes[k] = 8'h00;
      if (!in_frame && k == 0) frame_bytes[k] = ifss_pkg::FrameFlag;
      if (!in_frame && k == 1) frame_bytes[k] = tx_address;
      if (!in_frame && k == 2) frame_bytes[k] = hdr_ctl;
      if (!in_frame && k == 3) frame_bytes[k] = tx_address ^ hdr_ctl;
      if (Cw'(k) == hdr_len) frame_bytes[k] = data_b0;
      if (data_esc && Cw'(k) == hdr_len + Cw'(1)) frame_bytes[k] = data_b1;
      if (in_last && Cw'(k) == chk_pos) frame_bytes[k] = chk_b0;
      if (in_last && chk_esc && Cw'(k) == chk_pos + Cw'(1)) frame_bytes[k] = chk_b1;
      if (in_last && Cw'(k) == flag_pos) frame_bytes[k] = ifss_pkg::FrameFlag;
    end
    check_accum_next = in_last ? 8'h00 : check_new;
  end

  // Response parser for supervision frames.
  always_comb begin
    logic sup;
    sup = (in_data == ifss_pkg::CtlRr0) || (in_data == ifss_pkg::CtlRr1) ||
          (in_data == ifss_pkg::CtlRej0) || (in_data == ifss_pkg::CtlRej1);
    parse_state_next      = ifss_pkg::PsStart;
    captured_control_next = captured_control;
    seq_bit_next          = seq_bit;
    ev                    = ifss_pkg::EvNone;
    unique case (parse_state)
      ifss_pkg::PsFlag: begin
        if (in_data == tx_address) begin
          parse_state_next = ifss_pkg::PsAddr;
        end else if (in_data == ifss_pkg::FrameFlag) begin
          parse_state_next = ifss_pkg::PsFlag;
        end
      end
      ifss_pkg::PsAddr: begin
        if (sup) begin
          captured_control_next = in_data;
          parse_state_next      = ifss_pkg::PsCtrl;
        end else if (in_data == ifss_pkg::FrameFlag) begin
          parse_state_next = ifss_pkg::PsFlag;
        end
      end
      ifss_pkg::PsCtrl: begin
        if (in_data == (tx_address ^ captured_control)) begin
          parse_state_next = ifss_pkg::PsCheck;
        end
      end
      ifss_pkg::PsCheck: begin
        if (in_data == ifss_pkg::FrameFlag) begin
          // The receiver acknowledges by asking for the other sequence number.
          if (captured_control == (seq_bit ? ifss_pkg::CtlRr0 : ifss_pkg::CtlRr1)) begin
            seq_bit_next = !seq_bit;
            ev           = ifss_pkg::EvAck;
          end else begin
            ev = ifss_pkg::EvRetransmit;
          end
        end
      end
      default: begin
        if (in_data == ifss_pkg::FrameFlag) begin
          parse_state_next = ifss_pkg::PsFlag;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_address       <= ifss_pkg::AddrReset;
      in_valid         <= 1'b0;
      seq_bit          <= 1'b0;
      in_frame         <= 1'b0;
      check_accum      <= 8'h00;
      parse_state      <= ifss_pkg::PsStart;
      captured_control <= 8'h00;
      res_cnt          <= '0;
    end else begin
      if (cfg_wr_en) begin
        tx_address <= cfg_wr_data;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (load) begin
        if (in_cmd == ifss_pkg::CmdLine) begin
          parse_state      <= parse_state_next;
          captured_control <= captured_control_next;
          seq_bit          <= seq_bit_next;
          res_cnt          <= Cw'(1);
        end else begin
          in_frame    <= !in_last;
          check_accum <= check_accum_next;
          res_cnt     <= frame_cnt;
        end
      end else if (pop) begin
        res_cnt <= res_cnt - Cw'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_cmd  <= s_tuser;
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
    if (load) begin
      if (in_cmd == ifss_pkg::CmdLine) begin
        res_kind  <= ifss_pkg::KindStatus;
        res_event <= ev;
        res_seq   <= seq_bit_next;
        for (int k = 0; k < Nr; k++) begin
          res_bytes[k] <= 8'h00;
        end
      end else begin
        res_kind  <= ifss_pkg::KindTx;
        res_event <= ifss_pkg::EvNone;
        res_seq   <= seq_bit;
        for (int k = 0; k < Nr; k++) begin
          res_bytes[k] <= frame_bytes[k];
        end
      end
    end else if (pop) begin
      for (int k = 0; k < Nr - 1; k++) begin
        res_bytes[k] <= res_bytes[k+1];
      end
      res_bytes[Nr-1] <= 8'h00;
    end
  end

  assign m_tvalid = (res_cnt != '0);
  assign m_tuser  = res_kind;
  assign m_tlast  = (res_cnt == Cw'(1));
  assign m_tdata  = {5'b00000, res_seq, res_event, res_bytes[0]};

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= Cw'(Nr))
    else $error("result count exceeds buffer depth");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_kind == ifss_pkg::KindStatus) |-> (res_cnt == Cw'(1)))
    else $error("status result is not a single word");

  a_tx_no_event: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_kind == ifss_pkg::KindTx) |-> (res_event == ifss_pkg::EvNone))
    else $error("line byte carries an event");

  a_seq_on_ack: assert property (@(posedge clk) disable iff (rst)
    (seq_bit != seq_bit_next && load && in_cmd == ifss_pkg::CmdLine) |->
      (ev == ifss_pkg::EvAck))
    else $error("sequence bit toggled without acknowledge");

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 250;
  localparam int unsigned PhaseItems = 57;

  typedef struct packed {
    logic             kind;
    logic [7:0]       line_byte;
    ifss_pkg::event_t ev;
    logic             seq;
    logic             run_end;
  } link_word_t;

  // Mirrors the framer and the response parser, and keeps the words the block owes.
  class link_scoreboard;
    link_word_t             words_due[$];
    logic [7:0]             address;
    logic                   seq;
    logic                   frame_open;
    logic [7:0]             fcs;
    ifss_pkg::parse_state_t pstate;
    logic [7:0]             ctl_seen;
    int                     errors;
    int                     words_checked;
    int                     acks;
    int                     retransmits;
    int                     payload_words;
    int                     line_words;

    function new();
      address = ifss_pkg::AddrReset;
      seq = 1'b0;
      frame_open = 1'b0;
      fcs = 8'h00;
      pstate = ifss_pkg::PsStart;
      ctl_seen = 8'h00;
      errors = 0;
      words_checked = 0;
      acks = 0;
      retransmits = 0;
      payload_words = 0;
      line_words = 0;
    endfunction

    function void set_address(logic [7:0] a);
      address = a;
    endfunction

    function int pending();
      return words_due.size();
    endfunction

    function void owe_tx(logic [7:0] b, logic fin);
      link_word_t w;
      w.kind = ifss_pkg::KindTx;
      w.line_byte = b;
      w.ev = ifss_pkg::EvNone;
      w.seq = seq;
      w.run_end = fin;
      words_due.push_back(w);
    endfunction

    // Queues a stuffed byte; fin marks the word that closes this input word's run.
    function void owe_stuffed(logic [7:0] b, logic fin);
      if (b == ifss_pkg::FrameFlag) begin
        owe_tx(ifss_pkg::EscapeByte, 1'b0);
        owe_tx(ifss_pkg::FlagSub, fin);
      end else if (b == ifss_pkg::EscapeByte) begin
        owe_tx(ifss_pkg::EscapeByte, 1'b0);
        owe_tx(ifss_pkg::EscSub, fin);
      end else begin
        owe_tx(b, fin);
      end
    endfunction

    function ifss_pkg::event_t parse_line_byte(logic [7:0] b);
      ifss_pkg::event_t ev;
      ev = ifss_pkg::EvNone;
      case (pstate)
        ifss_pkg::PsFlag: begin
          if (b == address) pstate = ifss_pkg::PsAddr;
          else if (b != ifss_pkg::FrameFlag) pstate = ifss_pkg::PsStart;
        end
        ifss_pkg::PsAddr: begin
          if (b == ifss_pkg::CtlRr0 || b == ifss_pkg::CtlRr1 ||
              b == ifss_pkg::CtlRej0 || b == ifss_pkg::CtlRej1) begin
            ctl_seen = b;
            pstate = ifss_pkg::PsCtrl;
          end else if (b == ifss_pkg::FrameFlag) begin
            pstate = ifss_pkg::PsFlag;
          end else begin
            pstate = ifss_pkg::PsStart;
          end
        end
        ifss_pkg::PsCtrl: begin
          pstate = (b == (address ^ ctl_seen)) ? ifss_pkg::PsCheck : ifss_pkg::PsStart;
        end
        ifss_pkg::PsCheck: begin
          // Any byte here sends the parser back to start, even a flag.
          if (b == ifss_pkg::FrameFlag) begin
            if (ctl_seen == (seq ? ifss_pkg::CtlRr0 : ifss_pkg::CtlRr1)) begin
              seq = ~seq;
              ev = ifss_pkg::EvAck;
            end else begin
              ev = ifss_pkg::EvRetransmit;
            end
          end
          pstate = ifss_pkg::PsStart;
        end
        default: begin
          pstate = (b == ifss_pkg::FrameFlag) ? ifss_pkg::PsFlag : ifss_pkg::PsStart;
        end
      endcase
      return ev;
    endfunction

    function void note_word(logic cmd, logic [7:0] b, logic fin);
      link_word_t w;
      logic [7:0] ctl;
      if (cmd == ifss_pkg::CmdLine) begin
        line_words++;
        w.ev = parse_line_byte(b);
        if (w.ev == ifss_pkg::EvAck) acks++;
        if (w.ev == ifss_pkg::EvRetransmit) retransmits++;
        w.kind = ifss_pkg::KindStatus;
        w.line_byte = 8'h00;
        w.seq = seq;
        w.run_end = 1'b1;
        words_due.push_back(w);
      end else begin
        payload_words++;
        if (!frame_open) begin
          // The header goes out unstuffed.
          ctl = seq ? ifss_pkg::CtlI1 : ifss_pkg::CtlI0;
          owe_tx(ifss_pkg::FrameFlag, 1'b0);
          owe_tx(address, 1'b0);
          owe_tx(ctl, 1'b0);
          owe_tx(address ^ ctl, 1'b0);
          frame_open = 1'b1;
          fcs = 8'h00;
        end
        owe_stuffed(b, !fin);
        fcs = fcs ^ b;
        if (fin) begin
          owe_stuffed(fcs, 1'b0);
          owe_tx(ifss_pkg::FrameFlag, 1'b1);
          frame_open = 1'b0;
          fcs = 8'h00;
        end
      end
    endfunction

    function void check_word(logic user, logic [15:0] data, logic fin);
      link_word_t w;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: kind %0d byte %h event %0d seq %0d last %0d",
                   user, data[7:0], data[9:8], data[10], fin);
        return;
      end
      w = words_due.pop_front();
      words_checked++;
      if (user !== w.kind || data[7:0] !== w.line_byte || data[9:8] !== w.ev ||
          data[10] !== w.seq || fin !== w.run_end) begin
        errors++;
        if (errors <= 10)
          $display("word %0d: kind %0d/%0d byte %h/%h ev %0d/%0d seq %0d/%0d last %0d/%0d",
                   words_checked, w.kind, user, w.line_byte, data[7:0], w.ev, data[9:8],
                   w.seq, data[10], w.run_end, fin);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  link_scoreboard sb = new();
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int          phases = 0;

  info_frame_sender_stuffing_ack u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check accepted words, then pick the next m_tready.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_word(m_tuser, m_tdata, m_tlast);
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_word(input logic cmd, input logic [7:0] b, input logic fin);
    while (!quiet && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= b;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(cmd, b, fin);
  endtask

  // Sends the first n bytes of a response frame: flag, address, control, check, flag.
  task automatic send_response(input logic [7:0] addr, input logic [7:0] ctl,
                               input bit good, input int n);
    logic [7:0] frame_bytes [5];
    frame_bytes[0] = ifss_pkg::FrameFlag;
    frame_bytes[1] = addr;
    frame_bytes[2] = ctl;
    frame_bytes[3] = good ? (addr ^ ctl) : (addr ^ ctl ^ 8'($urandom_range(1, 255)));
    frame_bytes[4] = ifss_pkg::FrameFlag;
    for (int i = 0; i < n; i++)
      send_word(ifss_pkg::CmdLine, frame_bytes[i], 1'($urandom_range(1)));
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return ifss_pkg::FrameFlag;
    if (r < 30) return ifss_pkg::EscapeByte;
    return 8'($urandom_range(255));
  endfunction

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_address(a);
  endtask

  task automatic run_random(input int count);
    int sent;
    int n;
    int unsigned r;
    logic [7:0] ctl;
    logic [7:0] addr;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 40) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          send_word(ifss_pkg::CmdPayload, pick_byte(), i == n - 1);
        sent += n;
      end else if (r < 87) begin
        case ($urandom_range(5))
          0: ctl = ifss_pkg::CtlRr0;
          1: ctl = ifss_pkg::CtlRr1;
          2: ctl = ifss_pkg::CtlRej0;
          3: ctl = ifss_pkg::CtlRej1;
          default: ctl = sb.seq ? ifss_pkg::CtlRr0 : ifss_pkg::CtlRr1;
        endcase
        addr = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : sb.address;
        if ($urandom_range(4) == 0) begin
          send_word(ifss_pkg::CmdLine, ifss_pkg::FrameFlag, 1'b0);
          sent++;
        end
        // Most response frames are whole; some are cut short.
        n = (r < 75) ? 5 : $urandom_range(1, 4);
        send_response(addr, ctl, $urandom_range(6) != 0, n);
        sent += n;
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          send_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent += n;
      end
    end
  endtask

  initial begin
    logic [7:0] addrs [5];
    addrs[0] = 8'h00;
    addrs[1] = 8'hFF;
    addrs[2] = ifss_pkg::FrameFlag;
    addrs[3] = ifss_pkg::EscapeByte;
    addrs[4] = 8'($urandom_range(255));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-word frame that needs every stuffing step.
    send_word(ifss_pkg::CmdPayload, ifss_pkg::FrameFlag, 1'b1);
    send_word(ifss_pkg::CmdPayload, ifss_pkg::EscapeByte, 1'b0);
    send_word(ifss_pkg::CmdPayload, 8'hFF, 1'b1);
    // The expected RR moves the sequence to 1; the next header carries I1.
    send_response(sb.address, ifss_pkg::CtlRr1, 1'b1, 5);
    send_word(ifss_pkg::CmdPayload, 8'h00, 1'b1);
    send_response(sb.address, ifss_pkg::CtlRej0, 1'b1, 5);
    // A flag in the check position is a bad check.
    send_word(ifss_pkg::CmdLine, ifss_pkg::FrameFlag, 1'b0);
    send_word(ifss_pkg::CmdLine, sb.address, 1'b0);
    send_word(ifss_pkg::CmdLine, ifss_pkg::CtlRr0, 1'b0);
    send_word(ifss_pkg::CmdLine, ifss_pkg::FrameFlag, 1'b1);
    // Acknowledge arriving while a frame is open.
    send_word(ifss_pkg::CmdPayload, 8'h11, 1'b0);
    send_response(sb.address, ifss_pkg::CtlRr0, 1'b1, 5);
    send_word(ifss_pkg::CmdPayload, ifss_pkg::EscapeByte, 1'b1);
    settle();

    foreach (addrs[i]) begin
      write_address(addrs[i]);
      quiet = (i == 0);
      if (i == 1) hold_req = 1'b1;
      run_random(PhaseItems);
      settle();
      phases++;
    end
    quiet = 1'b0;

    $display("Sent %0d payload and %0d line words under %0d address settings after reset.",
             sb.payload_words, sb.line_words, phases + 1);
    $display("Checked %0d result words, %0d acks, %0d retransmit requests, %0d mismatches.",
             sb.words_checked, sb.acks, sb.retransmits, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
